/* hw/rtl/lkvc_pkg.sv */
package lkvc_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned LIMIT_W = 5;
  localparam int unsigned APB_W   = 32;
  localparam int unsigned ADDR_W  = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // register byte addresses, word index in the upper bits
  localparam logic [ADDR_W-1:0] REG_ENTRIES_IN_USE = 2'd0;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_SET = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                      command;
    logic signed [DATA_W-1:0]  key;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [DATA_W-1:0]  read_value;
    logic                      evicted;
    logic signed [DATA_W-1:0]  evicted_key;
  } rsp_t;

endpackage

/* hw/rtl/lru_key_value_cache_unit.sv */
// channel  direction  handshake            payload
// in_      request    in_valid/in_ready    in_data   (command, key, value)
// out_     result     out_valid/out_ready  out_data  (hit, read_value, evicted, evicted_key)
// cfg      register   psel/penable/pready  paddr, pwdata, prdata (entries_in_use)
//
// one item per cycle unless out_ready stalls; an item goes into req_r, its result into rsp_r
// the whole lookup, lru update and slot write happen in the stage after the input register
// rst_n synchronous active low: all slots invalid, limit back to 16
// a stalled result holds the pipeline, in_ready falls only when both stages are full and
// out_ready is low
module lru_key_value_cache_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lkvc_pkg::req_t                in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lkvc_pkg::rsp_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lkvc_pkg::ADDR_W-1:0]   paddr,
  input  logic [lkvc_pkg::APB_W-1:0]    pwdata,
  output logic [lkvc_pkg::APB_W-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic               req_vld_r;
  logic               req_vld_nxt;
  lkvc_pkg::req_t     req_r;
  logic               rsp_vld_r;
  logic               rsp_vld_nxt;
  lkvc_pkg::rsp_t     rsp_r;
  lkvc_pkg::rsp_t     rsp_comb;
  logic [CNT_W-1:0]   limit;
  logic               advance;
  logic               take;

  lkvc_cfg #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit   (limit)
  );

  lkvc_store #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .req   (req_r),
    .limit (limit),
    .rsp   (rsp_comb)
  );

  // the held item moves on when the result slot is free or being emptied
  assign advance  = req_vld_r && (!rsp_vld_r || out_ready);
  assign in_ready = !req_vld_r || advance;
  assign take     = in_valid && in_ready;

  assign out_valid = rsp_vld_r;
  assign out_data  = rsp_r;

  always_comb begin
    req_vld_nxt = req_vld_r;
    if (take) begin
      req_vld_nxt = 1'b1;
    end else if (advance) begin
      req_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    rsp_vld_nxt = rsp_vld_r;
    if (advance) begin
      rsp_vld_nxt = 1'b1;
    end else if (out_ready) begin
      rsp_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      rsp_vld_r <= 1'b0;
    end else begin
      req_vld_r <= req_vld_nxt;
      rsp_vld_r <= rsp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= in_data;
    end
    if (advance) begin
      rsp_r <= rsp_comb;
    end
  end

endmodule

/* hw/rtl/lkvc_cfg.sv */
module lkvc_cfg #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned CNT_W    = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lkvc_pkg::ADDR_W-1:0]     paddr,
  input  logic [lkvc_pkg::APB_W-1:0]      pwdata,
  output logic [lkvc_pkg::APB_W-1:0]      prdata,
  output logic                            pready,
  output logic [CNT_W-1:0]                limit
);

  localparam int unsigned CMP_W = (CNT_W > lkvc_pkg::LIMIT_W) ? CNT_W : lkvc_pkg::LIMIT_W;

  logic [lkvc_pkg::LIMIT_W-1:0] entries_r;
  logic [lkvc_pkg::LIMIT_W-1:0] entries_nxt;
  logic [CMP_W-1:0]             entries_ext;
  logic                         wr_en;
  logic                         reg_sel;

  assign pready  = 1'b1;
  // one register, mapped at byte address 0 only
  assign reg_sel = (paddr == lkvc_pkg::REG_ENTRIES_IN_USE);
  assign wr_en   = psel && penable && pwrite && reg_sel;

  always_comb begin
    entries_nxt = entries_r;
    if (wr_en) begin
      entries_nxt = pwdata[lkvc_pkg::LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= lkvc_pkg::LIMIT_RESET;
    end else begin
      entries_r <= entries_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(lkvc_pkg::APB_W - lkvc_pkg::LIMIT_W){1'b0}}, entries_r};
    end
  end

  // zero acts as one, anything above the slot count acts as the slot count
  always_comb begin
    entries_ext = CMP_W'(entries_r);
    if (entries_ext == '0) begin
      limit = CNT_W'(1);
    end else if (entries_ext > CMP_W'(CAPACITY)) begin
      limit = CNT_W'(CAPACITY);
    end else begin
      limit = CNT_W'(entries_ext);
    end
  end

endmodule

/* hw/rtl/lkvc_store.sv */
module lkvc_store #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned CNT_W    = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  lkvc_pkg::req_t    req,
  input  logic [CNT_W-1:0]  limit,
  output lkvc_pkg::rsp_t    rsp
);

  localparam int unsigned AGE_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [lkvc_pkg::DATA_W-1:0] key_r [CAPACITY];
  logic [lkvc_pkg::DATA_W-1:0] val_r [CAPACITY];
  logic [AGE_W-1:0]            age_r [CAPACITY];
  logic [AGE_W-1:0]            age_nxt [CAPACITY];
  logic [CAPACITY-1:0]         vld_r;
  logic [CAPACITY-1:0]         vld_nxt;
  logic [CNT_W-1:0]            cnt_r;
  logic [CNT_W-1:0]            cnt_nxt;

  logic [CAPACITY-1:0]         match;
  logic [CAPACITY-1:0]         oldest;
  logic [CAPACITY-1:0]         free_oh;
  logic [CAPACITY-1:0]         ins_oh;
  logic [AGE_W-1:0]            last_age;
  logic [AGE_W-1:0]            hit_age;
  logic [lkvc_pkg::DATA_W-1:0] hit_val;
  logic [lkvc_pkg::DATA_W-1:0] old_key;
  logic                        hit;
  logic                        is_set;
  logic                        evict;
  logic                        insert;

  assign is_set   = (req.command == lkvc_pkg::CMD_SET);
  assign last_age = AGE_W'(cnt_r - CNT_W'(1));

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]  = vld_r[i] && (key_r[i] == req.key);
      oldest[i] = vld_r[i] && (age_r[i] == last_age);
    end
  end

  // one-hot selects, keys are unique so at most one match
  always_comb begin
    hit_age = '0;
    hit_val = '0;
    old_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_age = hit_age | (match[i]  ? age_r[i] : '0);
      hit_val = hit_val | (match[i]  ? val_r[i] : '0);
      old_key = old_key | (oldest[i] ? key_r[i] : '0);
    end
  end

  assign hit     = |match;
  assign evict   = is_set && !hit && (cnt_r >= limit);
  assign insert  = is_set && !hit;
  // lowest free slot
  assign free_oh = ~vld_r & (vld_r + CAPACITY'(1));
  assign ins_oh  = evict ? oldest : free_oh;

  always_comb begin
    rsp.hit         = hit;
    rsp.read_value  = (hit && !is_set) ? hit_val : '0;
    rsp.evicted     = evict;
    rsp.evicted_key = evict ? old_key : '0;
  end

  always_comb begin
    vld_nxt = vld_r;
    cnt_nxt = cnt_r;
    for (int i = 0; i < CAPACITY; i++) begin
      age_nxt[i] = age_r[i];
      if (step) begin
        if (hit) begin
          if (match[i]) begin
            age_nxt[i] = '0;
          end else if (vld_r[i] && (age_r[i] < hit_age)) begin
            age_nxt[i] = age_r[i] + AGE_W'(1);
          end
        end else if (insert) begin
          if (ins_oh[i]) begin
            age_nxt[i] = '0;
            vld_nxt[i] = 1'b1;
          end else if (vld_r[i]) begin
            age_nxt[i] = age_r[i] + AGE_W'(1);
          end
        end
      end
    end
    if (step && insert && !evict) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cnt_r <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      vld_r <= vld_nxt;
      cnt_r <= cnt_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (step && hit && match[i] && is_set) begin
        val_r[i] <= req.value;
      end else if (step && insert && ins_oh[i]) begin
        key_r[i] <= req.key;
        val_r[i] <= req.value;
      end
    end
  end

  a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_r) == int'(cnt_r))
    else $error("entry count disagrees with valid bits");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= CAPACITY)
    else $error("entry count above capacity");

  a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("key present in more than one slot");

  a_victim_exists: assert property (@(posedge clk) disable iff (!rst_n)
    evict |-> $onehot(oldest))
    else $error("no unique least recent entry on eviction");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (step && insert && !evict) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert without eviction did not grow the count");

endmodule

/* bench/lru_cache_checker.sv */
module lru_cache_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  lkvc_pkg::req_t                in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  lkvc_pkg::rsp_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lkvc_pkg::ADDR_W-1:0]   paddr,
  input  logic [lkvc_pkg::APB_W-1:0]    pwdata,
  input  logic                          pready,
  output int                            fail_count,
  output int                            rsp_checked,
  output int                            rsp_queued
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [lkvc_pkg::DATA_W-1:0]  slot_key  [CAPACITY];
  logic [lkvc_pkg::DATA_W-1:0]  slot_val  [CAPACITY];
  logic                         slot_live [CAPACITY];
  int unsigned                  slot_rank [CAPACITY];
  logic [lkvc_pkg::LIMIT_W-1:0] entries_limit;

  lkvc_pkg::rsp_t pending_rsp [$];
  lkvc_pkg::rsp_t got;
  lkvc_pkg::rsp_t want;

  // every live entry more recent than rank_of ages by one, slot s goes to the front
  function automatic void bump_to_front(int s, int unsigned rank_of);
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_live[i] && slot_rank[i] < rank_of) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endfunction

  function automatic lkvc_pkg::rsp_t lru_access(lkvc_pkg::req_t r);
    lkvc_pkg::rsp_t res;
    int             hit_slot;
    int             lru_slot;
    int             free_slot;
    int unsigned    live_cnt;
    int unsigned    cap_now;
    res       = '0;
    hit_slot  = -1;
    lru_slot  = -1;
    free_slot = -1;
    live_cnt  = 0;
    cap_now   = (entries_limit == 0) ? 1 :
                (entries_limit > CAPACITY) ? CAPACITY : entries_limit;
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_live[i]) begin
        live_cnt++;
        if (slot_key[i] == r.key) hit_slot = i;
        if (lru_slot < 0 || slot_rank[i] > slot_rank[lru_slot]) lru_slot = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit_slot >= 0) begin
      res.hit = 1'b1;
      if (r.command == lkvc_pkg::CMD_GET) res.read_value = slot_val[hit_slot];
      else slot_val[hit_slot] = r.value;
      bump_to_front(hit_slot, slot_rank[hit_slot]);
    end else if (r.command == lkvc_pkg::CMD_SET) begin
      // evict first so a full store reuses the freed slot
      if (live_cnt + 1 > cap_now && lru_slot >= 0) begin
        res.evicted     = 1'b1;
        res.evicted_key = slot_key[lru_slot];
        slot_live[lru_slot] = 1'b0;
        slot_rank[lru_slot] = 0;
        free_slot = lru_slot;
      end
      if (free_slot >= 0) begin
        slot_key[free_slot]  = r.key;
        slot_val[free_slot]  = r.value;
        slot_live[free_slot] = 1'b0;
        bump_to_front(free_slot, 32'hFFFF_FFFF);
        slot_live[free_slot] = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic flag_field(input string fld, input logic [lkvc_pkg::DATA_W-1:0] want_v,
                            input logic [lkvc_pkg::DATA_W-1:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $display("%0t: %s expected %h got %h", $time, fld, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (slot_live[i]) begin
        slot_live[i] = 1'b0;
        slot_rank[i] = 0;
        slot_key[i]  = '0;
        slot_val[i]  = '0;
      end
      entries_limit = lkvc_pkg::LIMIT_RESET;
      pending_rsp.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (pending_rsp.size() == 0) begin
          fail_count++;
          $display("%0t: expected no item, got hit=%0b read_value=%h evicted=%0b evicted_key=%h",
                   $time, got.hit, got.read_value, got.evicted, got.evicted_key);
        end else begin
          want = pending_rsp.pop_front();
          rsp_checked++;
          flag_field("hit", lkvc_pkg::DATA_W'(want.hit), lkvc_pkg::DATA_W'(got.hit));
          flag_field("read_value", want.read_value, got.read_value);
          flag_field("evicted", lkvc_pkg::DATA_W'(want.evicted),
                     lkvc_pkg::DATA_W'(got.evicted));
          flag_field("evicted_key", want.evicted_key, got.evicted_key);
        end
      end
      if (psel && penable && pwrite && pready && paddr == lkvc_pkg::REG_ENTRIES_IN_USE) begin
        entries_limit = pwdata[lkvc_pkg::LIMIT_W-1:0];
      end
      if (in_valid && in_ready) pending_rsp.push_back(lru_access(in_data));
    end
    rsp_queued = pending_rsp.size();
  end

endmodule

/* bench/tb_lru_key_value_cache_unit.sv */
module tb_lru_key_value_cache_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = 16;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  lkvc_pkg::req_t              in_data   = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  lkvc_pkg::rsp_t              out_data;
  logic                        psel      = 1'b0;
  logic                        penable   = 1'b0;
  logic                        pwrite    = 1'b0;
  logic [lkvc_pkg::ADDR_W-1:0] paddr     = '0;
  logic [lkvc_pkg::APB_W-1:0]  pwdata    = '0;
  logic [lkvc_pkg::APB_W-1:0]  prdata;
  logic                        pready;

  int fail_count;
  int rsp_checked;
  int rsp_queued;
  int req_sent = 0;

  bit want_hold = 1'b0;
  bit hold_done = 1'b0;

  logic [lkvc_pkg::DATA_W-1:0]  key_pool [24];
  logic [lkvc_pkg::LIMIT_W-1:0] phase_limit [10] = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd1,
                                                     5'd7, 5'd16, 5'd3, 5'd12, 5'd4};

  lru_key_value_cache_unit #(.CAPACITY(CAP)) uut (.*);

  lru_cache_checker #(.CAPACITY(CAP)) u_check (.*);

  initial forever #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random ready runs, one long hold-off on request
  initial begin
    int   run;
    int   r;
    logic lvl;
    @(posedge clk);
    forever begin
      if (want_hold && !hold_done) begin
        lvl       = 1'b0;
        run       = 80;
        hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          lvl = 1'b1;
          run = $urandom_range(1, 12);
        end else if (r < 95) begin
          lvl = 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          lvl = 1'b0;
          run = $urandom_range(10, 40);
        end
      end
      out_ready <= lvl;
      repeat (run) @(posedge clk);
    end
  end

  function automatic logic [lkvc_pkg::DATA_W-1:0] pick_key(int span);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, span - 1)];
  endfunction

  function automatic logic [lkvc_pkg::DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) == 0) return key_pool[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  task automatic send_req(input lkvc_pkg::cmd_t c, input logic [lkvc_pkg::DATA_W-1:0] k,
                          input logic [lkvc_pkg::DATA_W-1:0] v);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = (r < 70) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: c, key: k, value: v};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    req_sent++;
  endtask

  // sender stops until every outstanding item has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (rsp_checked != req_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [lkvc_pkg::LIMIT_W-1:0] n);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lkvc_pkg::REG_ENTRIES_IN_USE;
    pwdata  <= lkvc_pkg::APB_W'(n);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int span;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 24; i++) key_pool[i] = $urandom;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty lookup, extreme keys and values, update in place
    send_req(lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
    send_req(lkvc_pkg::CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    send_req(lkvc_pkg::CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    send_req(lkvc_pkg::CMD_SET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_req(lkvc_pkg::CMD_SET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_req(lkvc_pkg::CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_req(lkvc_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_req(lkvc_pkg::CMD_GET, 32'h7FFF_FFFE, 32'h0000_0000);
    send_req(lkvc_pkg::CMD_SET, 32'h0000_0000, 32'h1234_5678);
    send_req(lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
    send_req(lkvc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    drain();
    // limit dropped under the count: one eviction per new key
    write_limit(5'd1);
    send_req(lkvc_pkg::CMD_SET, 32'h0000_0005, 32'h0000_0005);
    send_req(lkvc_pkg::CMD_SET, 32'h0000_0006, 32'hA5A5_5A5A);
    send_req(lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000);
    send_req(lkvc_pkg::CMD_GET, 32'h0000_0006, 32'h0000_0000);
    send_req(lkvc_pkg::CMD_SET, 32'h0000_0006, 32'h0000_0001);
    drain();

    foreach (phase_limit[p]) begin
      write_limit(phase_limit[p]);
      span = (phase_limit[p] == 0) ? 1 : (phase_limit[p] > CAP) ? CAP : phase_limit[p];
      span = (span + 5 > 24) ? 24 : span + 5;
      if (p == 1) want_hold = 1'b1;
      repeat (60) send_req(lkvc_pkg::cmd_t'($urandom_range(0, 1)), pick_key(span),
                           pick_value());
      drain();
    end

    if (fail_count == 0 && rsp_queued == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* lru_key_value_cache_unit.f */
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_cfg.sv
hw/rtl/lkvc_store.sv
hw/rtl/lru_key_value_cache_unit.sv
bench/lru_cache_checker.sv
bench/tb_lru_key_value_cache_unit.sv
